// ----- rtl/slm_pkg.sv -----
// Shared types and constants for the sorted list merger.
package slm_pkg;

  localparam int VALUE_W = 32;
  localparam int LEN_W   = 5;
  localparam int OP_W    = 2;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd4;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic out_free;
    logic last;
  } dp_sts_t;

endpackage

// ----- rtl/slm_ctrl.sv -----
// Controller state machine for the sorted list merger.
module slm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic [slm_pkg::OP_W-1:0] op,
  output logic                   s_tready,
  input  slm_pkg::dp_sts_t       sts,
  output slm_pkg::dp_cmd_t       cmd
);
  import slm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && op == OP_MERGE && !sts.n_zero) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          state_next = sts.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.load_a = s_tvalid && op == OP_LOAD_A;
        cmd.load_b = s_tvalid && op == OP_LOAD_B;
        cmd.start  = s_tvalid && op == OP_MERGE;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A result is only produced when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free) else $error("emit while output busy");

  // The memory read state is always followed directly by the compare state.
  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_EMIT) else $error("read not followed by emit");

  // No new request is taken while a merge walk is running.
  a_no_load_in_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_EMIT) |-> !(cmd.load_a || cmd.load_b || cmd.start))
    else $error("request taken during merge");

endmodule

// ----- rtl/slm_dp.sv -----
// Datapath for the sorted list merger: list stores, fill counts, heads and output register.
module slm_dp #(
  parameter int HALF_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [slm_pkg::LEN_W-1:0]     cfg_data,
  input  logic [slm_pkg::VALUE_W-1:0]   item_value,
  input  slm_pkg::dp_cmd_t              cmd,
  output slm_pkg::dp_sts_t              sts,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [slm_pkg::VALUE_W-1:0]   m_tdata,
  output logic                          m_tlast
);
  import slm_pkg::*;

  localparam int IW = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;
  localparam int CW = $clog2(HALF_MAX + 1);

  logic [LEN_W-1:0]   half_length;
  logic [5:0]         n_wide;
  logic [CW-1:0]      n;
  logic [CW-1:0]      fill_a;
  logic [CW-1:0]      fill_b;
  logic [CW-1:0]      head_a;
  logic [CW-1:0]      head_b;
  logic [VALUE_W-1:0] mem_a [HALF_MAX];
  logic [VALUE_W-1:0] mem_b [HALF_MAX];
  logic signed [VALUE_W-1:0] rd_a;
  logic signed [VALUE_W-1:0] rd_b;
  logic               a_live;
  logic               b_live;
  logic               pick_a;
  logic               last;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= LEN_RESET;
    end else if (cfg_valid) begin
      half_length <= cfg_data;
    end
  end

  // Lengths above the store depth saturate to the depth.
  assign n_wide = (6'(half_length) > 6'(HALF_MAX)) ? 6'(HALF_MAX) : 6'(half_length);
  assign n      = n_wide[CW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_a && fill_a < n) begin
      mem_a[fill_a[IW-1:0]] <= item_value;
    end
    if (cmd.load_b && fill_b < n) begin
      mem_b[fill_b[IW-1:0]] <= item_value;
    end
    rd_a <= mem_a[head_a[IW-1:0]];
    rd_b <= mem_b[head_b[IW-1:0]];
  end

  // A merge empties both lists as it starts; no load can arrive during the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_a <= '0;
      fill_b <= '0;
    end else if (cmd.start) begin
      fill_a <= '0;
      fill_b <= '0;
    end else begin
      if (cmd.load_a && fill_a < n) begin
        fill_a <= fill_a + 1'b1;
      end
      if (cmd.load_b && fill_b < n) begin
        fill_b <= fill_b + 1'b1;
      end
    end
  end

  assign a_live = head_a < n;
  assign b_live = head_b < n;
  // On equal heads the A value goes first.
  assign pick_a = a_live && (!b_live || !(rd_b < rd_a));
  assign last   = pick_a ? (head_a + 1'b1 == n && !b_live)
                         : (!a_live && head_b + 1'b1 == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_a <= '0;
      head_b <= '0;
    end else if (cmd.start) begin
      head_a <= '0;
      head_b <= '0;
    end else if (cmd.emit) begin
      if (pick_a) begin
        head_a <= head_a + 1'b1;
      end else begin
        head_b <= head_b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= pick_a ? rd_a : rd_b;
      m_tlast <= last;
    end
  end

  assign sts.n_zero   = (n == '0);
  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.last     = last;

  // A shorter length may leave a fill count above it, but never above the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_a <= CW'(HALF_MAX) && fill_b <= CW'(HALF_MAX))
    else $error("fill count beyond store depth");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid) else $error("emitted result not shown");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (a_live || b_live)) else $error("emit with both lists exhausted");

endmodule

// ----- rtl/sorted_list_merger.sv -----
// Top level of the sorted list merger.
//
//  channel | direction | handshake              | payload
//  s_*     | in        | s_tvalid / s_tready    | s_tdata value, s_tuser op
//  m_*     | out       | m_tvalid / m_tready    | m_tdata merged value, m_tlast
//  cfg_*   | in        | cfg_valid / cfg_ready  | cfg_data half_length
//
// A load request is taken while idle. A merge request starts the walk, then each
// result takes a registered list read, then the compare and the output register;
// a merge gives 2*n results. A stalled output holds the walk in its compare step.
// The stores need no clearing after reset; only the fill counts, heads, half_length,
// m_tvalid and the controller state are reset.
module sorted_list_merger #(
  parameter int HALF_MAX = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] item_value
  input  logic [1:0]  s_tuser,  // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] merged_value
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data  // [4:0] half_length
);
  import slm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slm_dp #(
    .HALF_MAX (HALF_MAX)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_value (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// ----- verif/sorted_list_merger_tb.sv -----
// Self-checking testbench for the sorted list merger: directed table, then random phases.
`timescale 1ns / 100ps

module sorted_list_merger_tb;
  import slm_pkg::*;

  localparam int HALF_MAX = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam longint TOP = 64'sd2147483647;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic signed [31:0] value;
    logic               typed;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } merged_t;

  // Rows marked typed carry their expected run in MERGE_OF_EXTREMES below.
  localparam request_t DIRECTED [21] = '{
    '{OP_LOAD_A, WORD_MIN, 1'b0},
    '{OP_LOAD_B, WORD_MIN, 1'b0},
    '{OP_LOAD_A, -32'sd1, 1'b0},
    '{OP_LOAD_B, 32'sd0, 1'b0},
    '{OP_LOAD_A, 32'sd0, 1'b0},
    '{OP_LOAD_B, 32'sd5, 1'b0},
    '{OP_LOAD_A, WORD_MAX, 1'b0},
    '{OP_LOAD_B, WORD_MAX, 1'b0},
    '{OP_LOAD_A, 32'sd7, 1'b0},
    '{OP_UNUSED, 32'sh5A5A_5A5A, 1'b0},
    '{OP_MERGE, -32'sd1, 1'b1},
    '{OP_MERGE, 32'sd0, 1'b1},
    '{OP_LOAD_A, 32'sd9, 1'b0},
    '{OP_LOAD_A, -32'sd3, 1'b0},
    '{OP_LOAD_B, 32'sd2, 1'b0},
    '{OP_LOAD_A, 32'sd40, 1'b0},
    '{OP_LOAD_B, -32'sd8, 1'b0},
    '{OP_LOAD_B, 32'sd100, 1'b0},
    '{OP_LOAD_A, 32'sd1, 1'b0},
    '{OP_LOAD_B, 32'sd0, 1'b0},
    '{OP_MERGE, 32'sd0, 1'b0}
  };

  localparam logic signed [31:0] MERGE_OF_EXTREMES [8] = '{
    WORD_MIN, WORD_MIN, -32'sd1, 32'sd0, 32'sd0, 32'sd5, WORD_MAX, WORD_MAX
  };

  localparam logic [LEN_W-1:0] PHASE_LEN [9] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd2, 5'd16, 5'd5, 5'd13
  };

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [31:0]       s_tdata;   // [31:0] item_value
  logic [1:0]        s_tuser;   // [1:0] op
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;   // [31:0] merged_value
  logic              m_tlast;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data;  // [4:0] half_length

  // Mirror of the block's state.
  logic signed [31:0] list_a [HALF_MAX];
  logic signed [31:0] list_b [HALF_MAX];
  int                 fill_a;
  int                 fill_b;
  int                 written_a;
  int                 written_b;
  logic [LEN_W-1:0]   half_len;

  merged_t  merged_due [$];
  merged_t  head;
  int       fault_count;
  int       landed;
  int       tx_idle_pct;
  int       rx_idle_pct;

  sorted_list_merger #(
    .HALF_MAX(HALF_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("sorted_list_merger_tb: errors");
    $finish;
  end

  task automatic flag_fault(input string msg);
    $display("%0t: %s", $realtime, msg);
    fault_count++;
  endtask

  function automatic int list_len();
    return (half_len > HALF_MAX) ? HALF_MAX : int'(half_len);
  endfunction

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return 32'(signed'(longint'($urandom_range(8)) - 4));
      default: return $signed($urandom);
    endcase
  endfunction

  // Applies one accepted request to the mirror; returns 0 when the block ignores it.
  function automatic bit merge_lists_apply(input logic [OP_W-1:0] op,
                                           input logic signed [31:0] value,
                                           input bit typed);
    int n;
    int ia;
    int ib;
    int k;
    bit take_b;
    merged_t res;
    n = list_len();
    case (op)
      OP_LOAD_A: begin
        if (fill_a >= n) return 1'b0;
        list_a[fill_a] = value;
        fill_a++;
        if (fill_a > written_a) written_a = fill_a;
        return 1'b1;
      end
      OP_LOAD_B: begin
        if (fill_b >= n) return 1'b0;
        list_b[fill_b] = value;
        fill_b++;
        if (fill_b > written_b) written_b = fill_b;
        return 1'b1;
      end
      OP_MERGE: begin
        ia = 0;
        ib = 0;
        for (k = 0; k < 2 * n; k++) begin
          if (ia >= n) take_b = 1'b1;
          else if (ib >= n) take_b = 1'b0;
          else take_b = list_b[ib] < list_a[ia];  // equal heads: A goes first
          if (take_b) begin
            res.value = list_b[ib];
            ib++;
          end else begin
            res.value = list_a[ia];
            ia++;
          end
          res.last = (k == 2 * n - 1);
          if (!typed) merged_due.push_back(res);
        end
        if (typed) begin
          foreach (MERGE_OF_EXTREMES[j]) begin
            res.value = MERGE_OF_EXTREMES[j];
            res.last = (j == 7);
            merged_due.push_back(res);
          end
        end
        fill_a = 0;
        fill_b = 0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_request(input logic [OP_W-1:0] op, input logic signed [31:0] value,
                               input bit typed);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    if (merge_lists_apply(op, value, typed)) landed++;
    @(negedge clk);
  endtask

  // Lets the block run dry; loads leave no result behind, hence the extra cycles.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (merged_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_half_length(input logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    half_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (merged_due.size() == 0) begin
        flag_fault($sformatf("result %0d with nothing pending", $signed(m_tdata)));
      end else begin
        head = merged_due.pop_front();
        if (m_tdata !== head.value)
          flag_fault($sformatf("merged_value %0d, want %0d", $signed(m_tdata), head.value));
        if (m_tlast !== head.last)
          flag_fault($sformatf("last %b, want %b", m_tlast, head.last));
      end
    end
  end

  initial begin
    request_t           plan [$];
    request_t           req;
    logic signed [31:0] vals_a [$];
    logic signed [31:0] vals_b [$];
    logic signed [31:0] word;
    longint             cur;
    int                 target;
    int                 n;
    int                 cnt;
    int                 roll;
    bit                 in_order;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fault_count = 0;
    landed = 0;
    fill_a = 0;
    fill_b = 0;
    written_a = 0;
    written_b = 0;
    half_len = LEN_RESET;
    tx_idle_pct = 11;
    rx_idle_pct = 55;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED[i]) offer_request(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].typed);

    foreach (PHASE_LEN[p]) begin
      settle();
      tx_idle_pct = (p < 3) ? 11 : (p < 6) ? 55 : 0;
      rx_idle_pct = (p < 3) ? 55 : (p < 6) ? 11 : 0;
      set_half_length(PHASE_LEN[p]);
      target = landed + ITEMS_PER_PHASE;
      while (landed < target || plan.size() != 0) begin
        if (plan.size() == 0) begin
          n = list_len();
          roll = $urandom_range(99);
          if (roll < 70) begin
            // Fill both lists up to the length, mostly in ascending order, then merge.
            in_order = ($urandom_range(99) < 85);
            for (int s = 0; s < 2; s++) begin
              cnt = n - ((s == 0) ? fill_a : fill_b);
              case ($urandom_range(3))
                0: cur = WORD_MIN;
                1: cur = longint'($urandom_range(200)) - 100;
                default: cur = longint'($signed($urandom));
              endcase
              for (int i = 0; i < cnt; i++) begin
                if (in_order) begin
                  if (i > 0) begin
                    case ($urandom_range(3))
                      0: ;
                      1: cur += $urandom_range(16);
                      default: cur += $urandom_range(32'h0FFF_FFFF);
                    endcase
                  end
                  if (cur > TOP) cur = TOP;
                  word = cur[31:0];
                end else begin
                  word = rand_word();
                end
                if (s == 0) vals_a.push_back(word);
                else vals_b.push_back(word);
              end
            end
            while (vals_a.size() + vals_b.size() != 0) begin
              if (vals_b.size() == 0 || (vals_a.size() != 0 && $urandom_range(1)))
                plan.push_back('{OP_LOAD_A, vals_a.pop_front(), 1'b0});
              else
                plan.push_back('{OP_LOAD_B, vals_b.pop_front(), 1'b0});
            end
            if ($urandom_range(9) == 0)
              plan.push_back('{($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B), rand_word(), 1'b0});
            if ($urandom_range(9) == 0) plan.push_back('{OP_UNUSED, rand_word(), 1'b0});
            plan.push_back('{OP_MERGE, rand_word(), 1'b0});
          end else if (roll < 85 && written_a >= n && written_b >= n) begin
            // Partly refilled lists: the merge reads older entries as stored.
            repeat ($urandom_range(2))
              plan.push_back('{($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B), rand_word(), 1'b0});
            plan.push_back('{OP_MERGE, rand_word(), 1'b0});
          end else begin
            repeat ($urandom_range(1, 4)) begin
              case ($urandom_range(2))
                0: plan.push_back('{OP_LOAD_A, rand_word(), 1'b0});
                1: plan.push_back('{OP_LOAD_B, rand_word(), 1'b0});
                default: plan.push_back('{OP_UNUSED, rand_word(), 1'b0});
              endcase
            end
          end
        end
        req = plan.pop_front();
        offer_request(req.op, req.value, 1'b0);
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("sorted_list_merger_tb: clean");
    end else begin
      $display("sorted_list_merger_tb: errors");
    end
    $finish;
  end

endmodule
